### design/m3d_pkg.sv
package m3d_pkg;

    localparam int MAX_WIDTH     = 2048;
    localparam int PIXEL_BITS    = 16;
    localparam int PORT_PIX_BITS = 16;
    localparam int COL_BITS      = $clog2(MAX_WIDTH);
    localparam int WEFF_BITS     = COL_BITS + 1;
    localparam int CFG_W_BITS    = 12;
    localparam int CFG_H_BITS    = 16;
    localparam int ROW_BITS      = 16;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 16;
    localparam int Q_DEPTH       = 8;
    localparam int Q_PTR_BITS    = $clog2(Q_DEPTH);
    localparam int Q_LVL_BITS    = Q_PTR_BITS + 1;
    localparam int STAGES        = 3;
    localparam int FLIGHT_BITS   = 2;

    localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_WIDTH  = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_HEIGHT = CFG_IDX_BITS'(1);

    localparam logic [CFG_W_BITS-1:0] WIDTH_RESET  = CFG_W_BITS'(2048);
    localparam logic [CFG_H_BITS-1:0] HEIGHT_RESET = CFG_H_BITS'(2048);

    typedef logic [PIXEL_BITS-1:0] pix_t;

    typedef enum logic [1:0] {
        SEL_MEDIAN,
        SEL_CENTER,
        SEL_LAST_UPPER,
        SEL_STORE
    } sel_t;

    typedef struct packed {
        logic                valid;
        logic                wr;
        logic [COL_BITS-1:0] addr;
        pix_t                pix;
        logic                emit;
        sel_t                sel;
        logic                use_mid;
        logic                last_col;
        logic                fend;
    } back_op_t;

    typedef struct packed {
        logic valid;
        pix_t pixel;
        logic fend;
    } result_t;

    function automatic pix_t min2(input pix_t a, input pix_t b);
        return (a < b) ? a : b;
    endfunction

    function automatic pix_t max2(input pix_t a, input pix_t b);
        return (a < b) ? b : a;
    endfunction

    function automatic pix_t med3(input pix_t a, input pix_t b, input pix_t c);
        return max2(min2(a, b), min2(max2(a, b), c));
    endfunction

endpackage

### design/m3d_in_if.sv
interface m3d_in_if import m3d_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic                     command;
    logic [PORT_PIX_BITS-1:0] pixel_in;

    modport source (output valid, output command, output pixel_in, input ready);
    modport sink   (input valid, input command, input pixel_in, output ready);
endinterface

### design/m3d_out_if.sv
interface m3d_out_if import m3d_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [PORT_PIX_BITS-1:0] pixel_out;
    logic                     frame_end;

    modport source (output valid, output pixel_out, output frame_end, input ready);
    modport sink   (input valid, input pixel_out, input frame_end, output ready);
endinterface

### design/m3d_cfg_if.sv
interface m3d_cfg_if import m3d_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [CFG_IDX_BITS-1:0]  index;
    logic [CFG_DATA_BITS-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### design/m3d_front.sv
module m3d_front import m3d_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    m3d_in_if.sink                 pix_in,
    m3d_cfg_if.sink                cfg,
    input  logic [Q_LVL_BITS-1:0]  q_level,
    input  logic [FLIGHT_BITS-1:0] in_flight,
    output back_op_t               op
);

    logic [CFG_W_BITS-1:0] width_reg, width_next;
    logic [CFG_H_BITS-1:0] height_reg, height_next;
    logic [COL_BITS-1:0]   icol_reg, icol_next;
    logic [ROW_BITS-1:0]   irow_reg, irow_next;
    logic [COL_BITS-1:0]   ocol_reg, ocol_next;
    logic [ROW_BITS-1:0]   orow_reg, orow_next;
    logic                  drain_reg, drain_next;

    logic [WEFF_BITS-1:0]  w_eff;
    logic [ROW_BITS-1:0]   h_eff;
    logic                  accept;

    function automatic pix_t pixel_in_masked(input logic [PORT_PIX_BITS-1:0] v);
        return v[PIXEL_BITS-1:0];
    endfunction

    assign cfg.ready    = 1'b1;
    assign pix_in.ready = ((Q_LVL_BITS + 1)'(q_level) + (Q_LVL_BITS + 1)'(in_flight))
                          < (Q_LVL_BITS + 1)'(Q_DEPTH);
    assign accept       = pix_in.valid && pix_in.ready;

    always_comb
    begin
        if (width_reg == '0)
            w_eff = WEFF_BITS'(1);
        else if (int'(width_reg) > MAX_WIDTH)
            w_eff = WEFF_BITS'(MAX_WIDTH);
        else
            w_eff = WEFF_BITS'(width_reg);
        h_eff = (height_reg == '0) ? ROW_BITS'(1) : ROW_BITS'(height_reg);
    end

    always_comb
    begin
        logic [COL_BITS-1:0] ic;
        logic [ROW_BITS-1:0] ir;
        logic [COL_BITS-1:0] oc;
        logic [ROW_BITS-1:0] orow;
        logic                dr;
        logic                emit;

        width_next  = width_reg;
        height_next = height_reg;
        icol_next   = icol_reg;
        irow_next   = irow_reg;
        ocol_next   = ocol_reg;
        orow_next   = orow_reg;
        drain_next  = drain_reg;
        op          = '0;
        ic          = icol_reg;
        ir          = irow_reg;
        oc          = ocol_reg;
        orow        = orow_reg;
        dr          = drain_reg;
        emit        = 1'b0;

        if (accept)
        begin
            if (pix_in.command)
            begin
                if (drain_reg && ({1'b0, ocol_reg} < w_eff))
                begin
                    op.valid   = 1'b1;
                    op.addr    = ocol_reg;
                    op.sel     = SEL_STORE;
                    op.use_mid = ((ROW_BITS + 1)'(orow_reg) + 1'b1) == (ROW_BITS + 1)'(h_eff);
                    op.emit    = 1'b1;
                    emit       = 1'b1;
                end
            end
            else
            begin
                if (drain_reg)
                begin
                    ic   = '0;
                    ir   = '0;
                    oc   = '0;
                    orow = '0;
                    dr   = 1'b0;
                end
                if ({1'b0, ic} < w_eff)
                begin
                    op.valid    = 1'b1;
                    op.wr       = 1'b1;
                    op.addr     = ic;
                    op.pix      = pixel_in_masked(pix_in.pixel_in);
                    op.last_col = ({1'b0, ic} == (w_eff - 1'b1));
                    if (ic == '0)
                    begin
                        emit   = (ir >= ROW_BITS'(2));
                        op.sel = SEL_LAST_UPPER;
                    end
                    else
                    begin
                        emit   = (ir >= ROW_BITS'(1));
                        op.sel = ((ir >= ROW_BITS'(2)) && (ic >= COL_BITS'(2)))
                                 ? SEL_MEDIAN : SEL_CENTER;
                    end
                    op.emit = emit;
                    if (({1'b0, ic} + 1'b1) >= w_eff)
                    begin
                        ic = '0;
                        if (((ROW_BITS + 1)'(ir) + 1'b1) >= (ROW_BITS + 1)'(h_eff))
                        begin
                            ir = '0;
                            dr = 1'b1;
                        end
                        else
                            ir = ir + 1'b1;
                    end
                    else
                        ic = ic + 1'b1;
                end
            end

            if (emit)
            begin
                if (({1'b0, oc} + 1'b1) >= w_eff)
                begin
                    oc = '0;
                    if (((ROW_BITS + 1)'(orow) + 1'b1) >= (ROW_BITS + 1)'(h_eff))
                    begin
                        orow    = '0;
                        dr      = 1'b0;
                        op.fend = 1'b1;
                    end
                    else
                        orow = orow + 1'b1;
                end
                else
                    oc = oc + 1'b1;
            end

            icol_next  = ic;
            irow_next  = ir;
            ocol_next  = oc;
            orow_next  = orow;
            drain_next = dr;
        end

        if (cfg.valid && ((cfg.index == REG_IMAGE_WIDTH) || (cfg.index == REG_IMAGE_HEIGHT)))
        begin
            if (cfg.index == REG_IMAGE_WIDTH)
                width_next = CFG_W_BITS'(cfg.data);
            else
                height_next = CFG_H_BITS'(cfg.data);
            icol_next  = '0;
            irow_next  = '0;
            ocol_next  = '0;
            orow_next  = '0;
            drain_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            icol_reg   <= '0;
            irow_reg   <= '0;
            ocol_reg   <= '0;
            orow_reg   <= '0;
            drain_reg  <= 1'b0;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            icol_reg   <= icol_next;
            irow_reg   <= irow_next;
            ocol_reg   <= ocol_next;
            orow_reg   <= orow_next;
            drain_reg  <= drain_next;
        end
    end

`ifndef SYNTH
    a_op_needs_accept: assert property (@(posedge clk) disable iff (!rst_n)
        op.valid |-> (pix_in.valid && pix_in.ready))
        else $error("back op issued without an input transaction");
`endif

endmodule

### design/m3d_back.sv
module m3d_back import m3d_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  back_op_t               op,
    output logic [FLIGHT_BITS-1:0] in_flight,
    output result_t                res
);

    logic [2*PIXEL_BITS-1:0] line_mem [MAX_WIDTH];
    logic [2*PIXEL_BITS-1:0] rd_reg;
    logic                    byp_reg, byp_next;
    logic [2*PIXEL_BITS-1:0] byp_data_reg;

    back_op_t s1_reg;

    // sorted columns, index 2 newest
    pix_t lo_reg [3];
    pix_t md_reg [3];
    pix_t hi_reg [3];
    pix_t ctr_reg;
    pix_t lu_reg;

    logic s2_valid_reg;
    logic s2_med_reg;
    logic s2_fend_reg;
    pix_t s2_raw_reg;

    logic s3_valid_reg;
    logic s3_med_reg;
    logic s3_fend_reg;
    pix_t s3_raw_reg;
    pix_t s3_a_reg, s3_b_reg, s3_c_reg;

    logic [2*PIXEL_BITS-1:0] entry;
    pix_t                    upper, middle;
    logic                    wr_en;
    logic [2*PIXEL_BITS-1:0] wr_data;
    pix_t                    col_lo, col_md, col_hi;
    pix_t                    s1_raw;

    assign entry   = byp_reg ? byp_data_reg : rd_reg;
    assign upper   = entry[2*PIXEL_BITS-1:PIXEL_BITS];
    assign middle  = entry[PIXEL_BITS-1:0];
    assign wr_en   = s1_reg.valid && s1_reg.wr;
    assign wr_data = {middle, s1_reg.pix};
    assign byp_next = op.valid && wr_en && (op.addr == s1_reg.addr);

    always_comb
    begin
        pix_t a, b, t;
        a      = min2(upper, middle);
        b      = max2(upper, middle);
        t      = max2(a, s1_reg.pix);
        col_lo = min2(a, s1_reg.pix);
        col_md = min2(t, b);
        col_hi = max2(t, b);
    end

    always_comb
    begin
        case (s1_reg.sel)
            SEL_STORE:      s1_raw = s1_reg.use_mid ? middle : upper;
            SEL_LAST_UPPER: s1_raw = lu_reg;
            SEL_CENTER:     s1_raw = ctr_reg;
            default:        s1_raw = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            line_mem[s1_reg.addr] <= wr_data;
        if (op.valid)
            rd_reg <= line_mem[op.addr];
    end

    always_ff @(posedge clk)
    begin
        byp_data_reg <= wr_data;
        if (wr_en)
        begin
            lo_reg[0] <= lo_reg[1];
            lo_reg[1] <= lo_reg[2];
            lo_reg[2] <= col_lo;
            md_reg[0] <= md_reg[1];
            md_reg[1] <= md_reg[2];
            md_reg[2] <= col_md;
            hi_reg[0] <= hi_reg[1];
            hi_reg[1] <= hi_reg[2];
            hi_reg[2] <= col_hi;
            ctr_reg   <= middle;
            if (s1_reg.last_col)
                lu_reg <= middle;
        end
        s2_raw_reg  <= s1_raw;
        s2_med_reg  <= (s1_reg.sel == SEL_MEDIAN);
        s2_fend_reg <= s1_reg.fend;
        s3_raw_reg  <= s2_raw_reg;
        s3_med_reg  <= s2_med_reg;
        s3_fend_reg <= s2_fend_reg;
        s3_a_reg    <= max2(max2(lo_reg[0], lo_reg[1]), lo_reg[2]);
        s3_b_reg    <= med3(md_reg[0], md_reg[1], md_reg[2]);
        s3_c_reg    <= min2(min2(hi_reg[0], hi_reg[1]), hi_reg[2]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg       <= '0;
            byp_reg      <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_reg       <= op;
            byp_reg      <= byp_next;
            s2_valid_reg <= s1_reg.valid && s1_reg.emit;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    assign in_flight = FLIGHT_BITS'(s1_reg.valid) + FLIGHT_BITS'(s2_valid_reg)
                       + FLIGHT_BITS'(s3_valid_reg);

    assign res.valid = s3_valid_reg;
    assign res.pixel = s3_med_reg ? med3(s3_a_reg, s3_b_reg, s3_c_reg) : s3_raw_reg;
    assign res.fend  = s3_fend_reg;

`ifndef SYNTH
    a_s3_follows_s2: assert property (@(posedge clk) disable iff (!rst_n)
        s3_valid_reg |-> $past(s2_valid_reg))
        else $error("result stage valid without a prior stage");
`endif

endmodule

### design/m3d_queue.sv
module m3d_queue import m3d_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  result_t               push,
    m3d_out_if.source             pix_out,
    output logic [Q_LVL_BITS-1:0] level
);

    pix_t                  pix_mem  [Q_DEPTH];
    logic                  fend_mem [Q_DEPTH];
    logic [Q_PTR_BITS-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [Q_LVL_BITS-1:0] level_reg, level_next;
    logic                  pop;

    assign pop               = pix_out.valid && pix_out.ready;
    assign pix_out.valid     = (level_reg != '0);
    assign pix_out.pixel_out = PORT_PIX_BITS'(pix_mem[rd_ptr_reg]);
    assign pix_out.frame_end = fend_mem[rd_ptr_reg];
    assign level             = level_reg;

    always_comb
    begin
        level_next = level_reg;
        if (push.valid && !pop)
            level_next = level_reg + 1'b1;
        else if (!push.valid && pop)
            level_next = level_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            pix_mem[wr_ptr_reg]  <= push.pixel;
            fend_mem[wr_ptr_reg] <= push.fend;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            if (push.valid)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            level_reg <= level_next;
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push.valid |-> (level_reg < Q_LVL_BITS'(Q_DEPTH)))
        else $error("result queue overflow");
`endif

`ifndef SYNTH
    a_level_track: assert property (@(posedge clk) disable iff (!rst_n)
        (push.valid && !pop) |=> (level_reg == $past(level_reg) + 1'b1))
        else $error("queue level did not count a push");
`endif

endmodule

### design/median3x3_despike_filter.sv
// 3x3 median despike filter for 16-bit pixels streamed in raster order. Each output is the
// median of the pixel's 3x3 neighborhood; first/last row and column pass through raw. Output
// lags input by one line plus one pixel; after the last pixel of a frame, send drain
// transactions (command=1) to flush the pending outputs, one per transaction. One transaction
// per clock is sustained while the output queue has room for every result in flight; an
// accepted input's output passes through the line-store read, the column sort and the median
// merge registers in turn, then lands in the output queue. Both line stores share one
// 2048 x 32 memory with one read and one write port. Writing a configuration register
// restarts the frame; write it only while idle.
module median3x3_despike_filter import m3d_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    m3d_in_if.sink     pix_in,
    m3d_out_if.source  pix_out,
    m3d_cfg_if.sink    cfg
);

    back_op_t               op;
    result_t                res;
    logic [Q_LVL_BITS-1:0]  q_level;
    logic [FLIGHT_BITS-1:0] in_flight;

    m3d_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_in    (pix_in),
        .cfg       (cfg),
        .q_level   (q_level),
        .in_flight (in_flight),
        .op        (op)
    );

    m3d_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .op        (op),
        .in_flight (in_flight),
        .res       (res)
    );

    m3d_queue u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (res),
        .pix_out (pix_out),
        .level   (q_level)
    );

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import m3d_pkg::*;

    typedef struct {
        pix_t pixel;
        logic fend;
    } out_pix_t;

    typedef enum int {
        OP_WIDTH,
        OP_HEIGHT,
        OP_PIXEL,
        OP_DRAIN
    } op_t;

    typedef struct {
        op_t  op;
        int   val;
        bit   has_exp;
        pix_t exp_pix;
        bit   exp_fend;
    } stim_row_t;

    logic clk;
    logic rst_n;

    m3d_in_if  in_if();
    m3d_out_if out_if();
    m3d_cfg_if cfg_if();

    median3x3_despike_filter dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .pix_in  (in_if),
        .pix_out (out_if),
        .cfg     (cfg_if)
    );

    // filter state mirror
    pix_t            upper_line[MAX_WIDTH];
    pix_t            middle_line[MAX_WIDTH];
    pix_t            win[9];
    int              in_col, in_row, out_col, out_row;
    bit              draining;
    logic [11:0]     width_reg;
    logic [15:0]     height_reg;

    out_pix_t        pending_pixels[$];
    int              errors;
    int              items_sent;
    int              src_idle_pct;
    int              snk_idle_pct;
    bit              hold_req;
    int              hold_cnt;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic void frame_restart();
        in_col = 0;
        in_row = 0;
        out_col = 0;
        out_row = 0;
        draining = 1'b0;
    endfunction

    function automatic int width_eff();
        int w;
        w = width_reg;
        if (w == 0) w = 1;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        return w;
    endfunction

    function automatic int height_eff();
        return (height_reg == 0) ? 1 : int'(height_reg);
    endfunction

    function automatic pix_t median_of_window();
        pix_t s[9];
        pix_t t;
        for (int i = 0; i < 9; i++) s[i] = win[i];
        for (int i = 0; i < 9; i++)
            for (int j = 0; j < 8 - i; j++)
                if (s[j] > s[j+1])
                begin
                    t = s[j];
                    s[j] = s[j+1];
                    s[j+1] = t;
                end
        return s[4];
    endfunction

    function automatic bit step_output(input int w, input int h);
        out_col++;
        if (out_col >= w)
        begin
            out_col = 0;
            out_row++;
            if (out_row >= h)
            begin
                out_row = 0;
                draining = 1'b0;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic bit filter_step(input bit drain, input pix_t p,
                                       output pix_t v, output bit fe);
        int   w, h, ic, ir;
        pix_t last_up;
        bit   emit;
        w = width_eff();
        h = height_eff();
        emit = 1'b0;
        v = '0;
        fe = 1'b0;
        if (drain)
        begin
            if (!draining || out_col >= w) return 1'b0;
            v = (out_row + 1 == h) ? middle_line[out_col] : upper_line[out_col];
            fe = step_output(w, h);
            return 1'b1;
        end
        if (draining) frame_restart();
        ic = in_col;
        ir = in_row;
        if (ic >= w) return 1'b0;
        last_up = upper_line[w-1];
        for (int i = 0; i < 6; i++) win[i] = win[i+3];
        win[6] = upper_line[ic];
        win[7] = middle_line[ic];
        win[8] = p;
        upper_line[ic] = middle_line[ic];
        middle_line[ic] = p;
        if (ic == 0)
        begin
            if (ir >= 2)
            begin
                emit = 1'b1;
                v = last_up;
            end
        end
        else if (ir >= 1)
        begin
            emit = 1'b1;
            v = (ir >= 2 && ic >= 2) ? median_of_window() : win[4];
        end
        in_col = ic + 1;
        if (in_col >= w)
        begin
            in_col = 0;
            in_row = ir + 1;
            if (in_row >= h)
            begin
                in_row = 0;
                draining = 1'b1;
            end
        end
        if (!emit) return 1'b0;
        fe = step_output(w, h);
        return 1'b1;
    endfunction

    // called at a rising edge; leaves the transaction accepted at the current edge
    task automatic send_item(input bit drain, input pix_t p, input bit has_exp = 0,
                             input pix_t ep = '0, input bit ef = 0);
        pix_t v;
        bit   fe;
        bit   got;
        out_pix_t e;
        if ($urandom_range(0, 99) < src_idle_pct)
        begin
            in_if.valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(0, 99) < src_idle_pct);
        end
        in_if.valid    <= 1'b1;
        in_if.command  <= drain;
        in_if.pixel_in <= p;
        @(posedge clk);
        while (!in_if.ready) @(posedge clk);
        got = filter_step(drain, p, v, fe);
        if (has_exp)
        begin
            if (!got)
            begin
                $display("%0t: directed row expects a result, mirror gives none", $time);
                errors++;
            end
            e.pixel = ep;
            e.fend = ef;
            pending_pixels.push_back(e);
        end
        else if (got)
        begin
            e.pixel = v;
            e.fend = fe;
            pending_pixels.push_back(e);
        end
        items_sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [15:0] d);
        in_if.valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge clk);
        repeat (12) @(posedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= d;
        @(posedge clk);
        while (!cfg_if.ready) @(posedge clk);
        cfg_if.valid <= 1'b0;
        if (idx == REG_IMAGE_WIDTH) width_reg = d[11:0];
        else height_reg = d;
        frame_restart();
    endtask

    function automatic pix_t rand_pixel();
        case ($urandom_range(0, 7))
            0, 1:    return pix_t'($urandom_range(0, 65535));
            2, 3:    return pix_t'($urandom_range(0, 3));
            4:       return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            5:       return pix_t'($urandom_range(1000, 1010));
            default: return $urandom_range(0, 9) == 0 ? 16'hFFFF
                                                        : pix_t'($urandom_range(100, 120));
        endcase
    endfunction

    task automatic run_frame(input logic [15:0] w, input logic [15:0] h, input int rows,
                             input bit new_cfg, input int drains);
        int n;
        if (new_cfg)
        begin
            write_reg(REG_IMAGE_WIDTH, w);
            write_reg(REG_IMAGE_HEIGHT, h);
        end
        n = rows * width_eff();
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 99) < 3) send_item(1'b1, pix_t'($urandom));
            send_item(1'b0, rand_pixel());
        end
        for (int i = 0; i < drains; i++) send_item(1'b1, pix_t'($urandom));
    endtask

    stim_row_t directed[] = '{
        '{OP_WIDTH,  1,       0, 16'h0000, 0},
        '{OP_HEIGHT, 1,       0, 16'h0000, 0},
        '{OP_PIXEL,  'hFFFF,  0, 16'h0000, 0},
        '{OP_DRAIN,  0,       1, 16'hFFFF, 1},
        '{OP_DRAIN,  0,       0, 16'h0000, 0},
        '{OP_WIDTH,  0,       0, 16'h0000, 0},
        '{OP_HEIGHT, 0,       0, 16'h0000, 0},
        '{OP_PIXEL,  0,       0, 16'h0000, 0},
        '{OP_DRAIN,  'hFFFF,  1, 16'h0000, 1},
        '{OP_WIDTH,  3,       0, 16'h0000, 0},
        '{OP_HEIGHT, 3,       0, 16'h0000, 0},
        '{OP_PIXEL,  1,       0, 16'h0000, 0},
        '{OP_PIXEL,  2,       0, 16'h0000, 0},
        '{OP_PIXEL,  3,       0, 16'h0000, 0},
        '{OP_PIXEL,  4,       0, 16'h0000, 0},
        '{OP_PIXEL,  'hFFFF,  1, 16'h0001, 0},
        '{OP_PIXEL,  6,       0, 16'h0000, 0},
        '{OP_PIXEL,  7,       0, 16'h0000, 0},
        '{OP_PIXEL,  8,       0, 16'h0000, 0},
        '{OP_PIXEL,  9,       1, 16'h0006, 0},
        '{OP_DRAIN,  0,       0, 16'h0000, 0},
        '{OP_DRAIN,  0,       0, 16'h0000, 0},
        '{OP_DRAIN,  0,       0, 16'h0000, 0},
        '{OP_DRAIN,  0,       1, 16'h0009, 1}
    };

    always @(posedge clk)
    begin
        if (hold_req)
        begin
            hold_req = 1'b0;
            hold_cnt = 400;
        end
        if (hold_cnt > 0)
        begin
            hold_cnt--;
            out_if.ready <= 1'b0;
        end
        else
            out_if.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end

    always @(posedge clk)
    begin
        out_pix_t e;
        if (rst_n && out_if.valid && out_if.ready)
        begin
            if (pending_pixels.size() == 0)
            begin
                $display("%0t: unexpected transaction pixel=%h frame_end=%b", $time,
                         out_if.pixel_out, out_if.frame_end);
                errors++;
            end
            else
            begin
                e = pending_pixels.pop_front();
                if (out_if.pixel_out !== e.pixel)
                begin
                    $display("%0t: pixel_out expected %h actual %h", $time, e.pixel,
                             out_if.pixel_out);
                    errors++;
                end
                if (out_if.frame_end !== e.fend)
                begin
                    $display("%0t: frame_end expected %b actual %b", $time, e.fend,
                             out_if.frame_end);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        #5ms;
        $display("median3x3_despike_filter regression: fail");
        $finish;
    end

    initial
    begin
        int frames;
        int w, h;
        errors = 0;
        items_sent = 0;
        src_idle_pct = 0;
        snk_idle_pct = 0;
        hold_req = 1'b0;
        hold_cnt = 0;
        rst_n = 1'b0;
        in_if.valid = 1'b0;
        in_if.command = 1'b0;
        in_if.pixel_in = '0;
        cfg_if.valid = 1'b0;
        cfg_if.index = '0;
        cfg_if.data = '0;
        out_if.ready = 1'b0;
        width_reg = WIDTH_RESET;
        height_reg = HEIGHT_RESET;
        for (int i = 0; i < MAX_WIDTH; i++)
        begin
            upper_line[i] = '0;
            middle_line[i] = '0;
        end
        for (int i = 0; i < 9; i++) win[i] = '0;
        frame_restart();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
        begin
            case (directed[i].op)
                OP_WIDTH:  write_reg(REG_IMAGE_WIDTH, 16'(directed[i].val));
                OP_HEIGHT: write_reg(REG_IMAGE_HEIGHT, 16'(directed[i].val));
                OP_PIXEL:  send_item(1'b0, pix_t'(directed[i].val), directed[i].has_exp,
                                     directed[i].exp_pix, directed[i].exp_fend);
                default:   send_item(1'b1, pix_t'(directed[i].val), directed[i].has_exp,
                                     directed[i].exp_pix, directed[i].exp_fend);
            endcase
        end

        // wide frame, with a long receiver hold-off
        in_if.valid <= 1'b0;
        @(posedge clk);
        hold_req = 1'b1;
        run_frame(16'd300, 16'd2, 2, 1'b1, 301);
        // tallest height, abandoned by the next register write
        run_frame(16'd3, 16'hFFFF, 12, 1'b1, 0);

        frames = 0;
        while (items_sent < 1250)
        begin
            case (frames % 4)
                0: begin src_idle_pct = 0;  snk_idle_pct = 0;  end
                1: begin src_idle_pct = 55; snk_idle_pct = 0;  end
                2: begin src_idle_pct = 0;  snk_idle_pct = 55; end
                default: begin src_idle_pct = 31; snk_idle_pct = 31; end
            endcase
            w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(1, 8);
            h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 12) : $urandom_range(1, 6);
            if ($urandom_range(0, 4) == 0)
            begin
                // partial drain, then a new frame while draining
                run_frame(16'(w), 16'(h), (h == 0) ? 1 : h, 1'b1, $urandom_range(0, w));
                run_frame(16'(w), 16'(h), (h == 0) ? 1 : h, 1'b0,
                          width_eff() + 1 + $urandom_range(0, 2));
            end
            else
                run_frame(16'(w), 16'(h), (h == 0) ? 1 : h, 1'b1,
                          width_eff() + 1 + $urandom_range(0, 2));
            frames++;
        end

        in_if.valid <= 1'b0;
        snk_idle_pct = 0;
        while (pending_pixels.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("median3x3_despike_filter regression: pass");
        else
            $display("median3x3_despike_filter regression: fail");
        $finish;
    end

endmodule
